// ----- hdl/shdb_pkg.sv -----
package shdb_pkg;

   // Defaults for the top-level parameters.
   localparam int NUM_STRATA_DEF = 64;
   localparam int COUNT_BITS_DEF = 32;

   // Fixed field widths.
   localparam int OP_W        = 3;
   localparam int STRATUM_W   = 6;
   localparam int AMOUNT_W    = 32;
   localparam int STRATA_W    = 7;
   localparam int FIELD_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB    = 3'd1;
   localparam logic [OP_W-1:0] OP_READ   = 3'd2;
   localparam logic [OP_W-1:0] OP_DECIDE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_STRATA   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_REPORTED = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_REPORTED = 2'd2;

   typedef enum logic [2:0] {
      KIND_ADD,
      KIND_SUB,
      KIND_READ,
      KIND_DECIDE,
      KIND_CLEAR,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [STRATUM_W-1:0]   stratum;
      logic [AMOUNT_W-1:0]    amount;
   } cmd_type;

   typedef struct packed {
      logic [STRATA_W-1:0] min_strata;
      logic [FIELD_W-1:0]  min_reported;
      logic [FIELD_W-1:0]  max_reported;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RMW,
      ST_READ,
      ST_SHRINK,
      ST_WALK_CHK,
      ST_WALK_EV,
      ST_FINISH
   } state_type;

   // Only strata that the stratum field can address are ever stored.
   function automatic int store_depth(input int num_strata);
      return (num_strata < (1 << STRATUM_W)) ? num_strata : (1 << STRATUM_W);
   endfunction

endpackage

// ----- hdl/strata_histogram_decode_budget_top.sv -----
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_stall   operation, stratum, amount
// rsp      out  rsp_valid/rsp_stall   stratum_count, grand_total, decode_strata,
//                                     partial_last, partial_amount, wrapped
// csr      in   csr_wr_en             csr_index, csr_wr_data
//
// Add and subtract read the counter RAM, then write back and register the result; read
// registers the count after the RAM read; clear and unused codes register the result at
// once. Decide drops empty strata from the top one at a time, then walks the strata and
// takes whole strata until the cap stops the walk; on an empty histogram it ends after the drops.
// Reset is synchronous and per-entry nonzero flags clear the histogram at once. A two-entry
// command queue keeps taking transactions while a result waits on rsp_stall, until it is full.
module strata_histogram_decode_budget_top import shdb_pkg::*; #(
   parameter int NUM_STRATA = NUM_STRATA_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [STRATUM_W-1:0]   req_stratum,
   input  logic [AMOUNT_W-1:0]    req_amount,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FIELD_W-1:0]     rsp_stratum_count,
   output logic [FIELD_W-1:0]     rsp_grand_total,
   output logic [STRATA_W-1:0]    rsp_decode_strata,
   output logic                   rsp_partial_last,
   output logic [FIELD_W-1:0]     rsp_partial_amount,
   output logic                   rsp_wrapped,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_STRATA:   cfg_in.min_strata   = csr_wr_data[STRATA_W-1:0];
            CSR_MIN_REPORTED: cfg_in.min_reported = csr_wr_data[FIELD_W-1:0];
            CSR_MAX_REPORTED: cfg_in.max_reported = csr_wr_data[FIELD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_strata   <= '0;
         cfg_ff.min_reported <= '0;
         cfg_ff.max_reported <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   shdb_front #(
      .NUM_STRATA (NUM_STRATA)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_stratum   (req_stratum),
      .req_amount    (req_amount),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   shdb_back #(
      .NUM_STRATA (NUM_STRATA),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stratum_count  (rsp_stratum_count),
      .rsp_grand_total    (rsp_grand_total),
      .rsp_decode_strata  (rsp_decode_strata),
      .rsp_partial_last   (rsp_partial_last),
      .rsp_partial_amount (rsp_partial_amount),
      .rsp_wrapped        (rsp_wrapped)
   );

endmodule

// ----- hdl/shdb_ram.sv -----
module shdb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/shdb_front.sv -----
module shdb_front import shdb_pkg::*; #(
   parameter int NUM_STRATA = NUM_STRATA_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [STRATUM_W-1:0] req_stratum,
   input  logic [AMOUNT_W-1:0]  req_amount,
   output logic                 cmd_valid,
   output cmd_type              cmd,
   input  logic                 cmd_pop
);

   localparam int STORE_DEPTH = store_depth(NUM_STRATA);
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   cmd_type            queue_ff [QUEUE_DEPTH];
   cmd_type            cmd_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               in_range;
   logic               push;

   // Classify the incoming transaction. Out-of-range strata and unused codes
   // collapse into one kind that only reports the total.
   always_comb begin
      in_range       = 32'(req_stratum) < 32'(STORE_DEPTH);
      cmd_in.stratum = req_stratum;
      cmd_in.amount  = req_amount;
      unique case (req_operation)
         OP_ADD:    cmd_in.kind = in_range ? KIND_ADD : KIND_NOP;
         OP_SUB:    cmd_in.kind = in_range ? KIND_SUB : KIND_NOP;
         OP_READ:   cmd_in.kind = in_range ? KIND_READ : KIND_NOP;
         OP_DECIDE: cmd_in.kind = KIND_DECIDE;
         OP_CLEAR:  cmd_in.kind = KIND_CLEAR;
         default:   cmd_in.kind = KIND_NOP;
      endcase
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ----- hdl/shdb_back.sv -----
module shdb_back import shdb_pkg::*; #(
   parameter int NUM_STRATA = NUM_STRATA_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [FIELD_W-1:0]  rsp_stratum_count,
   output logic [FIELD_W-1:0]  rsp_grand_total,
   output logic [STRATA_W-1:0] rsp_decode_strata,
   output logic                rsp_partial_last,
   output logic [FIELD_W-1:0]  rsp_partial_amount,
   output logic                rsp_wrapped
);

   localparam int STORE_DEPTH = store_depth(NUM_STRATA);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int WIDE_W      = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
   localparam int SUM_W       = WIDE_W + 1;

   state_type               state_ff, state_in;
   cmd_type                 work_ff, work_in;
   logic [STORE_DEPTH-1:0]  nz_ff, nz_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic [STRATA_W-1:0]     used_ff, used_in;
   logic [STRATA_W-1:0]     top_ff, top_in;
   logic [STRATA_W-1:0]     cur_ff, cur_in;
   logic [FIELD_W-1:0]      sum_ff, sum_in;
   logic [STRATA_W-1:0]     full_ff, full_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [FIELD_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [STRATA_W-1:0]     rsp_strata_ff, rsp_strata_in;
   logic                    rsp_plast_ff, rsp_plast_in;
   logic [FIELD_W-1:0]      rsp_pamt_ff, rsp_pamt_in;
   logic                    rsp_wrap_ff, rsp_wrap_in;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [COUNT_BITS-1:0]   ram_rdata;

   logic [ADDR_W-1:0]       work_addr, cur_addr, top_addr, rd_addr;
   logic [STRATA_W-1:0]     top_m1;
   logic [COUNT_BITS-1:0]   rd_count;
   logic                    out_free;
   logic                    is_sub;
   logic [SUM_W-1:0]        old_w, amt_w, tot_w, cnt_w, tot_new_w;
   logic [COUNT_BITS-1:0]   cnt_new, tot_new;
   logic                    cnt_wrap, tot_wrap;
   logic [FIELD_W-1:0]      avail;
   logic [WIDE_W-1:0]       c_wide, count_wide, total_wide;
   logic                    over;
   logic [FIELD_W-1:0]      sum_next;
   logic                    walk_go, partial, nonzero;
   logic                    load;
   logic [COUNT_BITS-1:0]   count_src;

   assign work_addr = work_ff.stratum[ADDR_W-1:0];
   assign cur_addr  = cur_ff[ADDR_W-1:0];
   assign top_m1    = top_ff - STRATA_W'(1);
   assign top_addr  = top_m1[ADDR_W-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // An entry whose nonzero flag is clear holds zero whatever the RAM has.
   assign rd_addr  = (state_ff == ST_WALK_EV) ? cur_addr : work_addr;
   assign rd_count = nz_ff[rd_addr] ? ram_rdata : '0;

   // Read-modify-write arithmetic with at least one spare bit to catch the wrap.
   always_comb begin
      is_sub    = (work_ff.kind == KIND_SUB);
      old_w     = SUM_W'(rd_count);
      amt_w     = SUM_W'(work_ff.amount);
      tot_w     = SUM_W'(total_ff);
      cnt_w     = is_sub ? (old_w - amt_w) : (old_w + amt_w);
      tot_new_w = is_sub ? (tot_w - amt_w) : (tot_w + amt_w);
      cnt_new   = cnt_w[COUNT_BITS-1:0];
      tot_new   = tot_new_w[COUNT_BITS-1:0];
      cnt_wrap  = is_sub ? (amt_w > old_w) : (|cnt_w[SUM_W-1:COUNT_BITS]);
      tot_wrap  = is_sub ? (amt_w > tot_w) : (|tot_new_w[SUM_W-1:COUNT_BITS]);
   end

   // Decide walk terms. The sum never exceeds max_reported, so it fits a field.
   always_comb begin
      avail    = cfg.max_reported - sum_ff;
      c_wide   = WIDE_W'(rd_count);
      over     = c_wide > WIDE_W'(avail);
      sum_next = sum_ff + c_wide[FIELD_W-1:0];
      walk_go  = (cur_ff < top_ff) &&
                 ((full_ff < cfg.min_strata) || (sum_ff < cfg.max_reported));
      partial  = (cur_ff < top_ff) && (sum_ff < cfg.min_reported);
      nonzero  = (sum_ff != '0) || (partial && nz_ff[cur_addr]);
   end

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      nz_in         = nz_ff;
      total_in      = total_ff;
      used_in       = used_ff;
      top_in        = top_ff;
      cur_in        = cur_ff;
      sum_in        = sum_ff;
      full_in       = full_ff;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_raddr     = cur_addr;
      load          = 1'b0;
      count_src     = '0;
      rsp_strata_in = '0;
      rsp_plast_in  = 1'b0;
      rsp_pamt_in   = '0;
      rsp_wrap_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = cmd.stratum[ADDR_W-1:0];
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               work_in = cmd;
               unique case (cmd.kind)
                  KIND_ADD, KIND_SUB: state_in = ST_RMW;
                  KIND_READ:          state_in = ST_READ;
                  KIND_DECIDE: begin
                     top_in   = used_ff;
                     state_in = ST_SHRINK;
                  end
                  KIND_CLEAR: begin
                     nz_in    = '0;
                     total_in = '0;
                     used_in  = '0;
                     load     = 1'b1;
                  end
                  default: load = 1'b1;
               endcase
            end
         end
         ST_RMW: begin
            ram_we              = 1'b1;
            nz_in[work_addr]    = (cnt_new != '0);
            total_in            = tot_new;
            if (!is_sub && (STRATA_W'(work_ff.stratum) >= used_ff)) begin
               used_in = STRATA_W'(work_ff.stratum) + STRATA_W'(1);
            end
            count_src   = cnt_new;
            rsp_wrap_in = cnt_wrap || tot_wrap;
            load        = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_READ: begin
            count_src = rd_count;
            load      = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SHRINK: begin
            // Drop empty strata from the top, one per cycle.
            if (top_ff == '0) begin
               used_in  = '0;
               load     = 1'b1;
               state_in = ST_IDLE;
            end else if (nz_ff[top_addr]) begin
               used_in  = top_ff;
               cur_in   = '0;
               sum_in   = '0;
               full_in  = '0;
               state_in = ST_WALK_CHK;
            end else begin
               top_in = top_m1;
            end
         end
         ST_WALK_CHK: begin
            ram_raddr = cur_addr;
            state_in  = walk_go ? ST_WALK_EV : ST_FINISH;
         end
         ST_WALK_EV: begin
            if (over) begin
               state_in = ST_FINISH;
            end else begin
               sum_in = sum_next;
               cur_in = cur_ff + STRATA_W'(1);
               if (sum_next != '0) begin
                  full_in = full_ff + STRATA_W'(1);
               end
               state_in = ST_WALK_CHK;
            end
         end
         ST_FINISH: begin
            // The partial amount counts from the sum before the extra stratum.
            if (nonzero) begin
               rsp_strata_in = partial ? (cur_ff + STRATA_W'(1)) : cur_ff;
               rsp_plast_in  = partial;
               rsp_pamt_in   = partial ? (cfg.min_reported - sum_ff) : '0;
            end
            load     = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      count_wide   = WIDE_W'(count_src);
      total_wide   = WIDE_W'(total_in);
      rsp_count_in = count_wide[FIELD_W-1:0];
      rsp_total_in = total_wide[FIELD_W-1:0];
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nz_ff        <= '0;
         total_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nz_ff        <= nz_in;
         total_ff     <= total_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      top_ff  <= top_in;
      cur_ff  <= cur_in;
      sum_ff  <= sum_in;
      full_ff <= full_in;
      if (load) begin
         rsp_count_ff  <= rsp_count_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_strata_ff <= rsp_strata_in;
         rsp_plast_ff  <= rsp_plast_in;
         rsp_pamt_ff   <= rsp_pamt_in;
         rsp_wrap_ff   <= rsp_wrap_in;
      end
   end

   shdb_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_counts (
      .clock (clock),
      .we    (ram_we),
      .waddr (work_addr),
      .wdata (cnt_new),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stratum_count  = rsp_count_ff;
   assign rsp_grand_total    = rsp_total_ff;
   assign rsp_decode_strata  = rsp_strata_ff;
   assign rsp_partial_last   = rsp_plast_ff;
   assign rsp_partial_amount = rsp_pamt_ff;
   assign rsp_wrapped        = rsp_wrap_ff;

endmodule

// ----- hdl/shdb_checker.sv -----
module shdb_checker import shdb_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [FIELD_W-1:0]  rsp_stratum_count,
   input logic [FIELD_W-1:0]  rsp_grand_total,
   input logic [STRATA_W-1:0] rsp_decode_strata,
   input logic                rsp_partial_last,
   input logic [FIELD_W-1:0]  rsp_partial_amount,
   input logic                rsp_wrapped
);

   // A stalled result stays in place until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_stratum_count) &&
         $stable(rsp_grand_total) && $stable(rsp_decode_strata) &&
         $stable(rsp_partial_last) && $stable(rsp_partial_amount) &&
         $stable(rsp_wrapped))
      else $error("result changed or dropped while stalled");

   // Reset empties the command queue and the output register.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // Only an add or a subtract can wrap, and those never carry a decision.
   a_wrap_no_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wrapped |-> rsp_decode_strata == '0 && !rsp_partial_last)
      else $error("wrap flag on a decide transaction");

   // A partial stratum is always part of a nonempty decision.
   a_partial_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_partial_last |-> rsp_decode_strata != '0 &&
         rsp_stratum_count == '0)
      else $error("partial stratum without a decision");

endmodule

bind strata_histogram_decode_budget_top shdb_checker u_shdb_checker (.*);
